// ----- rtl/rbl_pkg.sv -----
// Shared types, codes and reset values for the request back-off limiter.
package rbl_pkg;

	localparam int TIME_BITS = 48;
	localparam int GAP_BITS  = 16;
	localparam int SPAN_BITS = 24;
	localparam int CNT_BITS  = 4;
	localparam int WAIT_BITS = 25;
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	localparam logic [GAP_BITS-1:0]  HOST_GAP_RST    = 16'd1000;
	localparam logic [GAP_BITS-1:0]  GAP_CAP_RST     = 16'd20000;
	localparam logic [CNT_BITS-1:0]  STRIKE_LIM_RST  = 4'd3;
	localparam logic [SPAN_BITS-1:0] OFFLINE_SPAN_RST = 24'd120000;
	localparam logic [SPAN_BITS-1:0] REST_SPAN_RST   = 24'd1800000;

	typedef enum logic [1:0] {
		OP_REQ     = 2'd0,
		OP_FAIL    = 2'd1,
		OP_SUCCESS = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_HOST_GAP     = 3'd0,
		REG_GAP_CAP      = 3'd1,
		REG_STRIKE_LIMIT = 3'd2,
		REG_OFFLINE_SPAN = 3'd3,
		REG_REST_SPAN    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [TIME_BITS-1:0] now_ms;
	} evt_t;

	typedef struct packed {
		logic                 blocked;
		logic [WAIT_BITS-1:0] wait_ms;
		logic [CNT_BITS-1:0]  strikes;
	} res_t;

	typedef struct packed {
		logic [GAP_BITS-1:0]  host_gap_ms;
		logic [GAP_BITS-1:0]  gap_wait_cap_ms;
		logic [CNT_BITS-1:0]  strike_limit;
		logic [SPAN_BITS-1:0] offline_span_ms;
		logic [SPAN_BITS-1:0] rest_span_ms;
	} cfg_t;

endpackage

// ----- rtl/request_backoff_limiter_core.sv -----
// Top level of the request back-off limiter: event pipeline and APB port.
// Every event word gives one result word. Sustained rate is one event per
// clock while the result side does not stall; a result word is presented
// once its event has passed from the input register into the result
// register. The limiter state is read and updated as an event moves
// between those registers, which is what keeps consecutive events back to
// back. Events are stalled only when both the input register and the result
// register are full and the result side is stalling. Settings are to be
// written through the APB port only while no event is in flight; the block
// itself does not enforce this.
module request_backoff_limiter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          evt_valid,
	output logic                          evt_stall,
	input  rbl_pkg::evt_t                 evt_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output rbl_pkg::res_t                 res_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbl_pkg::ADDR_BITS-1:0] paddr,
	input  logic [rbl_pkg::DATA_BITS-1:0] pwdata,
	output logic [rbl_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);

	rbl_pkg::cfg_t cfg;
	rbl_pkg::evt_t evt_s1;
	rbl_pkg::res_t res_s2, res_d;
	logic          vld_s1, vld_s2;
	logic          s2_free, fire;

	assign s2_free   = !vld_s2 || !res_stall;
	assign fire      = vld_s1 && s2_free;
	assign evt_stall = vld_s1 && !s2_free;
	assign res_valid = vld_s2;
	assign res_data  = res_s2;

	rbl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbl_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!evt_stall)
				vld_s1 <= evt_valid;
			if (s2_free)
				vld_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall)
			evt_s1 <= evt_data;
		if (fire)
			res_s2 <= res_d;
	end

	// a blocked request never carries a wait
	a_blocked_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.blocked |-> res_data.wait_ms == '0)
		else $error("blocked result with nonzero wait");

	// a held input word stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s2_free |=> vld_s1 && $stable(evt_s1))
		else $error("input register lost a stalled word");

	// only requests produce a wait
	a_nonreq_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt_s1.opcode != rbl_pkg::OP_REQ |=> res_valid && res_data.wait_ms == '0)
		else $error("non-request event produced a wait");

	// a success always clears the strike count
	a_success_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt_s1.opcode == rbl_pkg::OP_SUCCESS |=> res_data.strikes == '0)
		else $error("success did not clear strikes");

endmodule

// ----- rtl/rbl_cfg_regs.sv -----
// APB register file holding the limiter settings.
module rbl_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbl_pkg::ADDR_BITS-1:0] paddr,
	input  logic [rbl_pkg::DATA_BITS-1:0] pwdata,
	output logic [rbl_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output rbl_pkg::cfg_t                 cfg
);

	rbl_pkg::cfg_t     cfg_q;
	rbl_pkg::reg_idx_t idx;
	logic              wr;

	assign idx    = rbl_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.host_gap_ms     <= rbl_pkg::HOST_GAP_RST;
			cfg_q.gap_wait_cap_ms <= rbl_pkg::GAP_CAP_RST;
			cfg_q.strike_limit    <= rbl_pkg::STRIKE_LIM_RST;
			cfg_q.offline_span_ms <= rbl_pkg::OFFLINE_SPAN_RST;
			cfg_q.rest_span_ms    <= rbl_pkg::REST_SPAN_RST;
		end else if (wr) begin
			case (idx)
				rbl_pkg::REG_HOST_GAP:
					cfg_q.host_gap_ms <= pwdata[rbl_pkg::GAP_BITS-1:0];
				rbl_pkg::REG_GAP_CAP:
					cfg_q.gap_wait_cap_ms <= pwdata[rbl_pkg::GAP_BITS-1:0];
				rbl_pkg::REG_STRIKE_LIMIT:
					cfg_q.strike_limit <= pwdata[rbl_pkg::CNT_BITS-1:0];
				rbl_pkg::REG_OFFLINE_SPAN:
					cfg_q.offline_span_ms <= pwdata[rbl_pkg::SPAN_BITS-1:0];
				rbl_pkg::REG_REST_SPAN:
					cfg_q.rest_span_ms <= pwdata[rbl_pkg::SPAN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			rbl_pkg::REG_HOST_GAP:
				prdata = rbl_pkg::DATA_BITS'(cfg_q.host_gap_ms);
			rbl_pkg::REG_GAP_CAP:
				prdata = rbl_pkg::DATA_BITS'(cfg_q.gap_wait_cap_ms);
			rbl_pkg::REG_STRIKE_LIMIT:
				prdata = rbl_pkg::DATA_BITS'(cfg_q.strike_limit);
			rbl_pkg::REG_OFFLINE_SPAN:
				prdata = rbl_pkg::DATA_BITS'(cfg_q.offline_span_ms);
			rbl_pkg::REG_REST_SPAN:
				prdata = rbl_pkg::DATA_BITS'(cfg_q.rest_span_ms);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/rbl_engine.sv -----
// Limiter state and the combinational event evaluation.
module rbl_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  rbl_pkg::evt_t evt,
	input  rbl_pkg::cfg_t cfg,
	output rbl_pkg::res_t res
);

	localparam int TB = rbl_pkg::TIME_BITS;
	localparam int SB = rbl_pkg::SPAN_BITS;
	localparam int GB = rbl_pkg::GAP_BITS;
	localparam int CB = rbl_pkg::CNT_BITS;
	localparam int WB = rbl_pkg::WAIT_BITS;

	logic [TB-1:0] next_allowed_q, offline_until_q, rest_until_q;
	logic [CB-1:0] strike_q;

	logic [TB-1:0] next_allowed_d, offline_until_d, rest_until_d;
	logic [CB-1:0] strike_d;

	logic [TB-1:0] now;
	logic          offline;
	logic [TB-1:0] rest_diff, gap_diff;
	logic [SB-1:0] rest_part;
	logic [GB-1:0] gap_part;
	logic [WB-1:0] wait_sum;
	logic [CB-1:0] strike_inc;

	assign now = evt.now_ms;

	always_comb begin
		offline   = (offline_until_q != '0) && (now < offline_until_q);
		rest_diff = rest_until_q - now;
		gap_diff  = next_allowed_q - now;

		rest_part = '0;
		if (rest_until_q > now) begin
			// saturate so the wait fits its field when time runs backward
			if (rest_diff[TB-1:SB] != '0)
				rest_part = '1;
			else
				rest_part = rest_diff[SB-1:0];
		end

		gap_part = '0;
		if (next_allowed_q > now) begin
			if (gap_diff[TB-1:GB] != '0 || gap_diff[GB-1:0] > cfg.gap_wait_cap_ms)
				gap_part = cfg.gap_wait_cap_ms;
			else
				gap_part = gap_diff[GB-1:0];
		end

		wait_sum   = WB'(rest_part) + WB'(gap_part);
		strike_inc = strike_q + CB'(1);

		next_allowed_d  = next_allowed_q;
		offline_until_d = offline_until_q;
		rest_until_d    = rest_until_q;
		strike_d        = strike_q;
		res.blocked     = 1'b0;
		res.wait_ms     = '0;

		case (evt.opcode)
			rbl_pkg::OP_REQ: begin
				if (offline) begin
					res.blocked = 1'b1;
				end else begin
					offline_until_d = '0;
					res.wait_ms     = wait_sum;
					next_allowed_d  = now + TB'(wait_sum) + TB'(cfg.host_gap_ms);
				end
			end
			rbl_pkg::OP_FAIL: begin
				strike_d = strike_inc;
				if (strike_inc >= cfg.strike_limit) begin
					offline_until_d = now + TB'(cfg.offline_span_ms);
					rest_until_d    = now + TB'(cfg.rest_span_ms);
					strike_d        = '0;
				end
			end
			rbl_pkg::OP_SUCCESS: begin
				strike_d     = '0;
				rest_until_d = '0;
			end
			default: ;
		endcase

		res.strikes = strike_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_allowed_q  <= '0;
			offline_until_q <= '0;
			rest_until_q    <= '0;
			strike_q        <= '0;
		end else if (fire) begin
			next_allowed_q  <= next_allowed_d;
			offline_until_q <= offline_until_d;
			rest_until_q    <= rest_until_d;
			strike_q        <= strike_d;
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for request_backoff_limiter_core: APB setup, event stream, result check.
`timescale 1ns / 1ps

module tb_top;
	import rbl_pkg::*;

	localparam logic [1:0]           OP_UNUSED = 2'd3;
	localparam logic [TIME_BITS-1:0] REST_SAT  = 48'hFF_FFFF;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 evt_valid = 1'b0;
	logic                 evt_stall;
	evt_t                 evt_data  = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_data;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [ADDR_BITS-1:0] paddr     = '0;
	logic [DATA_BITS-1:0] pwdata    = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	request_backoff_limiter_core dut (
		.clk(clk), .arst_n(arst_n),
		.evt_valid(evt_valid), .evt_stall(evt_stall), .evt_data(evt_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// limiter shadow: settings and host timing state
	cfg_t                 lim_cfg;
	logic [TIME_BITS-1:0] next_slot_ms;
	logic [CNT_BITS-1:0]  fail_streak;
	logic [TIME_BITS-1:0] offline_end_ms;
	logic [TIME_BITS-1:0] rest_end_ms;

	evt_t pending_events[$];
	res_t expected_outcomes[$];

	logic                 evt_taken = 1'b0;
	logic                 send_paused = 1'b0;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   hold_cycles = 0;
	int                   mismatch_count = 0;
	int                   events_accepted = 0;
	int                   results_seen = 0;
	int                   blocked_seen = 0;
	int                   windows_opened = 0;
	int                   settings_used = 1;
	logic [TIME_BITS-1:0] stim_clock = '0;

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	function automatic res_t limiter_decide(evt_t ev);
		res_t                 r;
		logic [TIME_BITS-1:0] now;
		logic [TIME_BITS-1:0] rest_left;
		logic [TIME_BITS-1:0] slot_left;
		logic [WAIT_BITS-1:0] rest_part;
		logic [WAIT_BITS-1:0] gap_part;
		logic [WAIT_BITS-1:0] wait_total;
		now = ev.now_ms;
		r = '0;
		case (ev.opcode)
		OP_REQ: begin
			if (offline_end_ms != '0 && now < offline_end_ms) begin
				r.blocked = 1'b1;
			end else begin
				offline_end_ms = '0;
				rest_part = '0;
				gap_part = '0;
				if (rest_end_ms > now) begin
					rest_left = rest_end_ms - now;
					rest_part = (rest_left > REST_SAT) ? REST_SAT[WAIT_BITS-1:0]
						: rest_left[WAIT_BITS-1:0];
				end
				if (next_slot_ms > now) begin
					slot_left = next_slot_ms - now;
					gap_part = (slot_left > lim_cfg.gap_wait_cap_ms) ?
						WAIT_BITS'(lim_cfg.gap_wait_cap_ms) : slot_left[WAIT_BITS-1:0];
				end
				wait_total = rest_part + gap_part;
				next_slot_ms = now + wait_total + lim_cfg.host_gap_ms;
				r.wait_ms = wait_total;
			end
		end
		OP_FAIL: begin
			fail_streak = fail_streak + 1'b1;
			if (fail_streak >= lim_cfg.strike_limit) begin
				offline_end_ms = now + lim_cfg.offline_span_ms;
				rest_end_ms = now + lim_cfg.rest_span_ms;
				fail_streak = '0;
				windows_opened++;
			end
		end
		OP_SUCCESS: begin
			fail_streak = '0;
			rest_end_ms = '0;
		end
		default: ;
		endcase
		r.strikes = fail_streak;
		return r;
	endfunction

	// input side: a word accepted here gets its expected outcome queued
	always @(posedge clk) begin
		if (arst_n && evt_valid && !evt_stall) begin
			expected_outcomes.push_back(limiter_decide(evt_data));
			events_accepted++;
			evt_taken = 1'b1;
		end
	end

	// driver: a stalled word is held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
		end else if (!(evt_valid && !evt_taken)) begin
			if (evt_taken) begin
				pending_events.delete(0);
				evt_taken = 1'b0;
			end
			if (pending_events.size() != 0 && !send_paused &&
			    $urandom_range(99) >= send_idle_pct) begin
				evt_valid <= 1'b1;
				evt_data <= pending_events[0];
			end else begin
				evt_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_stall <= 1'b1;
			hold_cycles--;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_outcomes.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = expected_outcomes.pop_front();
				if (want.blocked)
					blocked_seen++;
				if (res_data.blocked !== want.blocked)
					report_mismatch($sformatf("blocked got %0b exp %0b",
						res_data.blocked, want.blocked));
				if (res_data.wait_ms !== want.wait_ms)
					report_mismatch($sformatf("wait_ms got %0d exp %0d",
						res_data.wait_ms, want.wait_ms));
				if (res_data.strikes !== want.strikes)
					report_mismatch($sformatf("strikes got %0d exp %0d",
						res_data.strikes, want.strikes));
			end
		end
	end

	// APB write, then read back through the same port
	task automatic write_reg(reg_idx_t idx, logic [DATA_BITS-1:0] value);
		logic [DATA_BITS-1:0] readback;
		logic [DATA_BITS-1:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_HOST_GAP: begin
			lim_cfg.host_gap_ms = value[GAP_BITS-1:0];
			want = DATA_BITS'(value[GAP_BITS-1:0]);
		end
		REG_GAP_CAP: begin
			lim_cfg.gap_wait_cap_ms = value[GAP_BITS-1:0];
			want = DATA_BITS'(value[GAP_BITS-1:0]);
		end
		REG_STRIKE_LIMIT: begin
			lim_cfg.strike_limit = value[CNT_BITS-1:0];
			want = DATA_BITS'(value[CNT_BITS-1:0]);
		end
		REG_OFFLINE_SPAN: begin
			lim_cfg.offline_span_ms = value[SPAN_BITS-1:0];
			want = DATA_BITS'(value[SPAN_BITS-1:0]);
		end
		default: begin
			lim_cfg.rest_span_ms = value[SPAN_BITS-1:0];
			want = DATA_BITS'(value[SPAN_BITS-1:0]);
		end
		endcase
		if (readback !== want)
			report_mismatch($sformatf("register %s read %0h exp %0h",
				idx.name(), readback, want));
	endtask

	task automatic apply_settings(int gap, int cap, int limit, int offline, int rest);
		write_reg(REG_HOST_GAP, gap);
		write_reg(REG_GAP_CAP, cap);
		write_reg(REG_STRIKE_LIMIT, limit);
		write_reg(REG_OFFLINE_SPAN, offline);
		write_reg(REG_REST_SPAN, rest);
		settings_used++;
	endtask

	task automatic add_event(logic [1:0] op, logic [TIME_BITS-1:0] now);
		evt_t ev;
		ev.opcode = op;
		ev.now_ms = now;
		pending_events.push_back(ev);
	endtask

	// mostly a forward-moving clock sized to the windows, with some jumps
	task automatic queue_random_events(int count);
		int pick;
		int op_pick;
		int ok_weight;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 3)
				stim_clock = {16'($urandom), 32'($urandom)};
			else if (pick < 5)
				stim_clock = '1 - $urandom_range(0, 32'h200_0000);
			else if (pick < 9)
				stim_clock = stim_clock - {8'($urandom), 32'($urandom)};
			else if (pick < 40)
				stim_clock = stim_clock + $urandom_range(0, 50);
			else if (pick < 80)
				stim_clock = stim_clock + $urandom_range(0, 4000);
			else
				stim_clock = stim_clock + $urandom_range(0, lim_cfg.offline_span_ms / 2 + 1);
			ok_weight = (lim_cfg.strike_limit >= 8) ? 2 : 15;
			op_pick = $urandom_range(0, 84 + ok_weight);
			if (op_pick < 50)
				add_event(OP_REQ, stim_clock);
			else if (op_pick < 80)
				add_event(OP_FAIL, stim_clock);
			else if (op_pick < 85)
				add_event(OP_UNUSED, stim_clock);
			else
				add_event(OP_SUCCESS, stim_clock);
		end
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0 || evt_valid || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic wait_accepted(int mark);
		while (events_accepted < mark)
			@(posedge clk);
	endtask

	initial begin
		lim_cfg = '{host_gap_ms: HOST_GAP_RST, gap_wait_cap_ms: GAP_CAP_RST,
			strike_limit: STRIKE_LIM_RST, offline_span_ms: OFFLINE_SPAN_RST,
			rest_span_ms: REST_SPAN_RST};
		next_slot_ms = '0;
		fail_streak = '0;
		offline_end_ms = '0;
		rest_end_ms = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: gap, three strikes, blocked, window end edge
		add_event(OP_REQ, 48'd0);
		add_event(OP_REQ, 48'd0);
		add_event(OP_FAIL, 48'd10);
		add_event(OP_FAIL, 48'd20);
		add_event(OP_FAIL, 48'd30);
		add_event(OP_REQ, 48'd40);
		add_event(OP_UNUSED, 48'd50);
		add_event(OP_REQ, 48'd120030);
		add_event(OP_SUCCESS, 48'd120031);
		add_event(OP_REQ, 48'hFFFF_FFFF_FFFF);
		wait_drained();

		// high extremes, limit zero: deadlines that wrap to zero, saturated rest
		apply_settings(16'hFFFF, 16'hFFFF, 0, 24'hFF_FFFF, 24'hFF_FFFF);
		add_event(OP_FAIL, 48'hFFFF_FF00_0001);
		add_event(OP_REQ, 48'd5);
		add_event(OP_FAIL, 48'h0100_0000_0000);
		add_event(OP_REQ, 48'h0100_00FF_FFFF);
		add_event(OP_REQ, 48'd3);
		add_event(OP_SUCCESS, 48'd3);
		add_event(OP_REQ, 48'd4);
		wait_drained();

		// low extremes: one strike opens zero-length windows
		apply_settings(0, 0, 1, 0, 0);
		add_event(OP_FAIL, 48'd100);
		add_event(OP_REQ, 48'd99);
		add_event(OP_REQ, 48'd100);
		add_event(OP_REQ, 48'd100);
		wait_drained();

		// random phase, no idling, reset values
		apply_settings(HOST_GAP_RST, GAP_CAP_RST, STRIKE_LIM_RST, OFFLINE_SPAN_RST,
			REST_SPAN_RST);
		stim_clock = 48'd1_000_000;
		queue_random_events(250);
		wait_drained();

		// sender idles; one full pause until every result is back
		apply_settings($urandom_range(0, 65535), $urandom_range(0, 3000), 15,
			$urandom_range(0, 200000), $urandom_range(0, 24'hFF_FFFF));
		send_idle_pct = 47;
		queue_random_events(250);
		wait_accepted(events_accepted + 120);
		send_paused = 1'b1;
		while (evt_valid || expected_outcomes.size() != 0)
			@(posedge clk);
		send_paused = 1'b0;
		wait_drained();

		// receiver stalls; one long hold-off fills the pipe
		apply_settings($urandom_range(0, 5000), $urandom_range(0, 65535),
			$urandom_range(1, 4), $urandom_range(1000, 300000),
			$urandom_range(0, 5_000_000));
		send_idle_pct = 0;
		recv_stall_pct = 47;
		queue_random_events(250);
		wait_accepted(events_accepted + 50);
		hold_cycles = 300;
		wait_drained();

		// both sides idle
		apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(1, 15), $urandom_range(0, 24'hFF_FFFF),
			$urandom_range(0, 24'hFF_FFFF));
		send_idle_pct = 28;
		recv_stall_pct = 28;
		queue_random_events(250);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Covered %0d events and %0d results across %0d register settings,",
			events_accepted, results_seen, settings_used);
		$display("with %0d blocked requests, %0d offline windows opened, under stalls.",
			blocked_seen, windows_opened);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", expected_outcomes.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
